### rtl/printf_conversion_formatter_macros.svh
// Assertion macros shared by the formatter RTL.
`ifndef PRINTF_CONVERSION_FORMATTER_MACROS_SVH
`define PRINTF_CONVERSION_FORMATTER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PCF_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("formatter check failed");

// Next-cycle implication.
`define PCF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("formatter check failed");

`endif

### rtl/pcf_pkg.sv
package pcf_pkg;

	localparam int unsigned MAX_FIELD_DEF = 64;

	localparam int unsigned BIN_W = 32;
	localparam int unsigned BCD_DIGITS = 10;
	localparam int unsigned BCD_W = 4 * BCD_DIGITS;
	localparam int unsigned CNT_W = $clog2(BIN_W);

	localparam int unsigned F_HASH = 0;
	localparam int unsigned F_PLUS = 1;
	localparam int unsigned F_SPC = 2;
	localparam int unsigned F_LEFT = 3;
	localparam int unsigned F_ZERO = 4;
	localparam int unsigned F_PREC = 5;

	localparam logic [7:0] CH_C = 8'h63;
	localparam logic [7:0] CH_D = 8'h64;
	localparam logic [7:0] CH_I = 8'h69;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CH_LX = 8'h78;
	localparam logic [7:0] CH_UX = 8'h58;
	localparam logic [7:0] CH_P = 8'h70;
	localparam logic [7:0] CH_PCT = 8'h25;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_NUL = 8'h00;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_SIZE,
		S_PLAN,
		S_EMIT
	} state_t;

	typedef enum logic [2:0] {
		K_CHR,
		K_DEC,
		K_HEX,
		K_PTR,
		K_UNK
	} kind_t;

	function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
		logic [7:0] n8;
		n8 = {4'b0, nib};
		if (nib < 4'd10)
			return CH_ZERO + n8;
		return (upper ? CH_UA : CH_LA) + n8 - 8'd10;
	endfunction

endpackage

### rtl/pcf_bcd.sv
module pcf_bcd (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pcf_pkg::BIN_W-1:0]      bin,
	output logic                           done,
	output logic [pcf_pkg::BCD_W-1:0]      bcd
);

	logic [pcf_pkg::BIN_W-1:0] sh_q;
	logic [pcf_pkg::BCD_W-1:0] bcd_q;
	logic [pcf_pkg::BCD_W-1:0] adj;
	logic [pcf_pkg::CNT_W-1:0] cnt_q;
	logic                      busy_q;
	logic                      done_q;

	// Shift-and-add-three: every digit of five or more is corrected before the shift.
	always_comb begin
		for (int d = 0; d < pcf_pkg::BCD_DIGITS; d++) begin
			adj[d*4 +: 4] = (bcd_q[d*4 +: 4] >= 4'd5) ? bcd_q[d*4 +: 4] + 4'd3
				: bcd_q[d*4 +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == pcf_pkg::CNT_W'(pcf_pkg::BIN_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pcf_pkg::CNT_W'(pcf_pkg::BIN_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {adj[pcf_pkg::BCD_W-2:0], sh_q[pcf_pkg::BIN_W-1]};
			sh_q <= {sh_q[pcf_pkg::BIN_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign bcd = bcd_q;

endmodule

### rtl/printf_conversion_formatter.sv
// Formats one parsed printf conversion into a stream of ASCII characters.
// Input channel: in_valid/in_stall carry func, flags, width, precision and value;
// a transaction is taken when in_valid is high and in_stall is low.
// Output channel: out_valid/out_stall carry out_char, char_valid and last, one
// character per transaction, last set on the final one. A conversion that
// yields nothing gives a single transaction with char_valid low and last high.
// Output is cut after MAX_FIELD characters.
// One conversion is handled at a time; in_stall stays high from acceptance
// until the last character has been loaded into the output register.
// c, %, x, X, p and unknown conversions pass through the sizing and planning
// states before the first character; d, i and u first wait in a conversion state
// while the bit-serial binary to BCD converter works on the 32-bit magnitude.
// Characters then follow at one per cycle while out_stall is low.
// A stall on the output holds the current character and pauses generation.
// Reset clears the sequencer and the output valid flag; the block is then idle.
module printf_conversion_formatter #(
	parameter int unsigned MAX_FIELD = pcf_pkg::MAX_FIELD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  func,
	input  logic [5:0]  flags,
	input  logic [6:0]  width,
	input  logic [5:0]  precision,
	input  logic [63:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_char,
	output logic        char_valid,
	output logic        last
);

	localparam int unsigned CW = $clog2(MAX_FIELD + 1);

	pcf_pkg::state_t state_q, state_d;
	pcf_pkg::kind_t  kind_d;

	logic        upper_q, left_q, zero_q;
	logic [5:0]  prec_q;
	logic [6:0]  width_q;
	logic [63:0] mag_q, digits_q;
	logic [7:0]  pre0_q, pre1_q;
	logic [1:0]  pl_q;
	logic [5:0]  ndig_q;
	logic [7:0]  b1_q, b2_q, b3_q, b4_q, total_q;
	logic [CW-1:0] n_q;

	logic        out_valid_q, char_valid_q, last_q;
	logic [7:0]  out_char_q;

	// Decode of the incoming item.
	logic        upper_d, zero_d, is_dec;
	logic [5:0]  prec_d;
	logic [6:0]  width_d;
	logic [63:0] mag_d;
	logic [7:0]  pre0_d, pre1_d;
	logic [1:0]  pl_d;
	logic [31:0] raw;
	logic        accept, bcd_done;
	logic [pcf_pkg::BCD_W-1:0] bcd;

	// Planning and emission.
	logic [4:0]  k;
	logic [5:0]  ndig_d;
	logic [6:0]  len, pad;
	logic [7:0]  padl, zp, padr, b1_d, b2_d, b3_d, b4_d, tot_d;
	logic [7:0]  nn, idx, ch;
	logic        emit_go, is_last;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != pcf_pkg::S_IDLE);
	assign raw = value[31:0];

	always_comb begin
		upper_d = 1'b0;
		zero_d = flags[pcf_pkg::F_ZERO] && !flags[pcf_pkg::F_PREC];
		prec_d = flags[pcf_pkg::F_PREC] ? precision : 6'd1;
		width_d = width;
		mag_d = 64'd0;
		pre0_d = pcf_pkg::CH_PCT;
		pre1_d = func;
		pl_d = 2'd0;
		is_dec = 1'b0;
		if (func inside {pcf_pkg::CH_C, pcf_pkg::CH_PCT}) begin
			kind_d = pcf_pkg::K_CHR;
			pre0_d = (func == pcf_pkg::CH_C) ? value[7:0] : pcf_pkg::CH_PCT;
			pl_d = 2'd1;
			prec_d = 6'd0;
			zero_d = 1'b0;
		end else if (func inside {pcf_pkg::CH_D, pcf_pkg::CH_I}) begin
			kind_d = pcf_pkg::K_DEC;
			is_dec = 1'b1;
			mag_d = {32'd0, raw[31] ? 32'd0 - raw : raw};
			if (raw[31]) begin
				pre0_d = pcf_pkg::CH_MINUS;
				pl_d = 2'd1;
			end else if (flags[pcf_pkg::F_PLUS]) begin
				pre0_d = pcf_pkg::CH_PLUS;
				pl_d = 2'd1;
			end else if (flags[pcf_pkg::F_SPC]) begin
				pre0_d = pcf_pkg::CH_SPACE;
				pl_d = 2'd1;
			end
		end else if (func == pcf_pkg::CH_U) begin
			kind_d = pcf_pkg::K_DEC;
			is_dec = 1'b1;
			mag_d = {32'd0, raw};
		end else if (func inside {pcf_pkg::CH_LX, pcf_pkg::CH_UX}) begin
			kind_d = pcf_pkg::K_HEX;
			upper_d = (func == pcf_pkg::CH_UX);
			mag_d = {32'd0, raw};
			pre0_d = pcf_pkg::CH_ZERO;
			if (flags[pcf_pkg::F_HASH] && raw != 32'd0)
				pl_d = 2'd2;
		end else if (func == pcf_pkg::CH_P) begin
			kind_d = pcf_pkg::K_PTR;
			mag_d = value;
			pre0_d = pcf_pkg::CH_ZERO;
			pre1_d = pcf_pkg::CH_LX;
			pl_d = 2'd2;
			prec_d = 6'd1;
			zero_d = 1'b0;
		end else begin
			kind_d = pcf_pkg::K_UNK;
			pl_d = 2'd2;
			prec_d = 6'd0;
			width_d = 7'd0;
			zero_d = 1'b0;
		end
		// The X conversion prints an upper case prefix letter.
		if (kind_d == pcf_pkg::K_HEX)
			pre1_d = upper_d ? pcf_pkg::CH_UX : pcf_pkg::CH_LX;
	end

	pcf_bcd u_bcd (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept && is_dec),
		.bin   (mag_d[31:0]),
		.done  (bcd_done),
		.bcd   (bcd)
	);

	// Number of significant digits, at least one, widened to the precision; zero for a zero value with zero precision.
	always_comb begin
		k = 5'd1;
		for (int i = 1; i < 16; i++) begin
			if (digits_q[i*4 +: 4] != 4'd0)
				k = 5'(i + 1);
		end
		if (mag_q == 64'd0 && prec_q == 6'd0)
			ndig_d = 6'd0;
		else
			ndig_d = ({1'b0, k} > prec_q) ? {1'b0, k} : prec_q;
	end

	always_comb begin
		len = 7'(ndig_q) + 7'(pl_q);
		pad = (width_q > len) ? width_q - len : 7'd0;
		padl = (!left_q && !zero_q) ? 8'(pad) : 8'd0;
		zp = (!left_q && zero_q) ? 8'(pad) : 8'd0;
		padr = left_q ? 8'(pad) : 8'd0;
		b1_d = padl;
		b2_d = b1_d + 8'(pl_q);
		b3_d = b2_d + zp;
		b4_d = b3_d + 8'(ndig_q);
		tot_d = b4_d + padr;
		if (tot_d > 8'(MAX_FIELD))
			tot_d = 8'(MAX_FIELD);
	end

	// Character at the current output position.
	always_comb begin
		nn = 8'(n_q);
		idx = b4_q - 8'd1 - nn;
		if (nn < b1_q)
			ch = pcf_pkg::CH_SPACE;
		else if (nn < b2_q)
			ch = (nn == b1_q) ? pre0_q : pre1_q;
		else if (nn < b3_q)
			ch = pcf_pkg::CH_ZERO;
		else if (nn < b4_q)
			ch = (idx < 8'd16) ? pcf_pkg::digit_char(digits_q[idx[3:0]*4 +: 4], upper_q)
				: pcf_pkg::CH_ZERO;
		else
			ch = pcf_pkg::CH_SPACE;
		is_last = (total_q == 8'd0) || (nn + 8'd1 == total_q);
	end

	always_comb begin
		state_d = state_q;
		emit_go = 1'b0;
		case (state_q)
			pcf_pkg::S_IDLE: begin
				if (accept)
					state_d = is_dec ? pcf_pkg::S_CONV : pcf_pkg::S_SIZE;
			end
			pcf_pkg::S_CONV: begin
				if (bcd_done)
					state_d = pcf_pkg::S_SIZE;
			end
			pcf_pkg::S_SIZE: state_d = pcf_pkg::S_PLAN;
			pcf_pkg::S_PLAN: state_d = pcf_pkg::S_EMIT;
			pcf_pkg::S_EMIT: begin
				emit_go = !out_valid_q || !out_stall;
				if (emit_go && is_last)
					state_d = pcf_pkg::S_IDLE;
			end
			default: state_d = pcf_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcf_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			n_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == pcf_pkg::S_PLAN)
				n_q <= '0;
			else if (emit_go)
				n_q <= n_q + 1'b1;
			if (emit_go)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			upper_q <= upper_d;
			left_q <= flags[pcf_pkg::F_LEFT];
			zero_q <= zero_d;
			prec_q <= prec_d;
			width_q <= width_d;
			mag_q <= mag_d;
			digits_q <= mag_d;
			pre0_q <= pre0_d;
			pre1_q <= pre1_d;
			pl_q <= pl_d;
		end else if (state_q == pcf_pkg::S_CONV && bcd_done) begin
			digits_q <= 64'(bcd);
		end
		if (state_q == pcf_pkg::S_SIZE)
			ndig_q <= ndig_d;
		if (state_q == pcf_pkg::S_PLAN) begin
			b1_q <= b1_d;
			b2_q <= b2_d;
			b3_q <= b3_d;
			b4_q <= b4_d;
			total_q <= tot_d;
		end
		if (emit_go) begin
			out_char_q <= (total_q == 8'd0) ? pcf_pkg::CH_NUL : ch;
			char_valid_q <= (total_q != 8'd0);
			last_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char = out_char_q;
	assign char_valid = char_valid_q;
	assign last = last_q;

`include "printf_conversion_formatter_macros.svh"

	`PCF_ASSERT_NEXT(a_busy_after_accept, accept, in_stall)
	`PCF_ASSERT_NEXT(a_hold_stalled, out_valid && out_stall, out_valid && $stable(out_char) && $stable(last))
	`PCF_ASSERT_IMPL(a_count_bound, 1'b1, 8'(n_q) <= 8'(MAX_FIELD))

endmodule

### test/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_CHARS = 64;
	localparam int LIMIT = 2000000;

	typedef struct packed {
		logic [7:0] ch;
		logic       cv;
		logic       lst;
	} fmt_char_t;

	typedef byte unsigned byte_q[$];

	// Appends a character while the field limit allows.
	function automatic void add_char(ref byte unsigned s[$], input byte unsigned c);
		if (s.size() < MAX_CHARS)
			s.push_back(c);
	endfunction

	function automatic void add_pad(ref byte unsigned s[$], input byte unsigned c,
			input int w, input int len);
		for (int i = len; i < w; i++)
			add_char(s, c);
	endfunction

	// Digits most significant first, without the precision zeros.
	function automatic void to_digits(ref byte unsigned d[$], input logic [63:0] num,
			input int base, input bit upper);
		logic [63:0] n;
		logic [3:0] r;
		n = num;
		d.delete();
		do begin
			r = 4'(n % base);
			d.push_front(r < 4'd10 ? 8'(pcf_pkg::CH_ZERO + r)
				: 8'((upper ? pcf_pkg::CH_UA : pcf_pkg::CH_LA) + r - 8'd10));
			n = n / base;
		end while (n != 0);
	endfunction

	function automatic void number_len(input logic [63:0] num, input int prec,
			input int base, input bit upper, output int len);
		byte unsigned d[$];
		len = 0;
		if (num == 0 && prec == 0)
			return;
		to_digits(d, num, base, upper);
		len = d.size() > prec ? d.size() : prec;
	endfunction

	function automatic void put_number(ref byte unsigned s[$], input logic [63:0] num,
			input int prec, input int base, input bit upper);
		byte unsigned d[$];
		if (num == 0 && prec == 0)
			return;
		to_digits(d, num, base, upper);
		for (int i = d.size(); i < prec; i++)
			add_char(s, pcf_pkg::CH_ZERO);
		foreach (d[i])
			add_char(s, d[i]);
	endfunction

	function automatic byte_q format_conversion(logic [7:0] fn, logic [5:0] fl,
			logic [6:0] w, logic [5:0] pr, logic [63:0] v);
		byte unsigned s[$];
		int prec, len, base, wi;
		bit left, zero, neg, pre, upper;
		logic [31:0] raw, mag;
		byte unsigned sign;
		wi = int'(w);
		prec = fl[pcf_pkg::F_PREC] ? int'(pr) : 1;
		left = fl[pcf_pkg::F_LEFT];
		zero = fl[pcf_pkg::F_ZERO] && !fl[pcf_pkg::F_PREC];
		if (fn == pcf_pkg::CH_C || fn == pcf_pkg::CH_PCT) begin
			if (!left)
				add_pad(s, pcf_pkg::CH_SPACE, wi, 1);
			add_char(s, fn == pcf_pkg::CH_C ? v[7:0] : pcf_pkg::CH_PCT);
			if (left)
				add_pad(s, pcf_pkg::CH_SPACE, wi, 1);
		end else if (fn == pcf_pkg::CH_D || fn == pcf_pkg::CH_I || fn == pcf_pkg::CH_U
				|| fn == pcf_pkg::CH_LX || fn == pcf_pkg::CH_UX) begin
			raw = v[31:0];
			neg = (fn == pcf_pkg::CH_D || fn == pcf_pkg::CH_I) && raw[31];
			mag = neg ? -raw : raw;
			base = (fn == pcf_pkg::CH_LX || fn == pcf_pkg::CH_UX) ? 16 : 10;
			upper = fn == pcf_pkg::CH_UX;
			sign = pcf_pkg::CH_NUL;
			if (fn == pcf_pkg::CH_D || fn == pcf_pkg::CH_I)
				sign = neg ? pcf_pkg::CH_MINUS : fl[pcf_pkg::F_PLUS] ? pcf_pkg::CH_PLUS
					: fl[pcf_pkg::F_SPC] ? pcf_pkg::CH_SPACE : pcf_pkg::CH_NUL;
			pre = base == 16 && fl[pcf_pkg::F_HASH] && mag != 0;
			number_len(64'(mag), prec, base, upper, len);
			len += (sign != 0) + (pre ? 2 : 0);
			if (!left && !zero)
				add_pad(s, pcf_pkg::CH_SPACE, wi, len);
			if (sign != 0)
				add_char(s, sign);
			if (pre) begin
				add_char(s, pcf_pkg::CH_ZERO);
				add_char(s, upper ? pcf_pkg::CH_UX : pcf_pkg::CH_LX);
			end
			if (!left && zero)
				add_pad(s, pcf_pkg::CH_ZERO, wi, len);
			put_number(s, 64'(mag), prec, base, upper);
			if (left)
				add_pad(s, pcf_pkg::CH_SPACE, wi, len);
		end else if (fn == pcf_pkg::CH_P) begin
			number_len(v, 1, 16, 1'b0, len);
			len += 2;
			if (!left)
				add_pad(s, pcf_pkg::CH_SPACE, wi, len);
			add_char(s, pcf_pkg::CH_ZERO);
			add_char(s, pcf_pkg::CH_LX);
			put_number(s, v, 1, 16, 1'b0);
			if (left)
				add_pad(s, pcf_pkg::CH_SPACE, wi, len);
		end else begin
			add_char(s, pcf_pkg::CH_PCT);
			add_char(s, fn);
		end
		return s;
	endfunction

	class format_scoreboard;
		fmt_char_t pending[$];
		int errors;

		function void note_conversion(logic [7:0] fn, logic [5:0] fl, logic [6:0] w,
				logic [5:0] pr, logic [63:0] v);
			fmt_char_t c;
			byte unsigned text[$];
			text = format_conversion(fn, fl, w, pr, v);
			if (text.size() == 0) begin
				c.ch = pcf_pkg::CH_NUL;
				c.cv = 1'b0;
				c.lst = 1'b1;
				pending.push_back(c);
			end else begin
				foreach (text[k]) begin
					c.ch = text[k];
					c.cv = 1'b1;
					c.lst = (k == text.size() - 1);
					pending.push_back(c);
				end
			end
		endfunction

		function void check_char(logic [7:0] ch, logic cv, logic lst);
			fmt_char_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected character, expected none, actual %h cv %b last %b",
					$realtime, ch, cv, lst);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (ch !== e.ch) begin
				$display("%0t: out_char expected %h actual %h", $realtime, e.ch, ch);
				errors++;
			end
			if (cv !== e.cv) begin
				$display("%0t: char_valid expected %b actual %b", $realtime, e.cv, cv);
				errors++;
			end
			if (lst !== e.lst) begin
				$display("%0t: last expected %b actual %b", $realtime, e.lst, lst);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  func = '0;
	logic [5:0]  flags = '0;
	logic [6:0]  width = '0;
	logic [5:0]  precision = '0;
	logic [63:0] value = '0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	logic [7:0]  out_char;
	logic        char_valid;
	logic        last;

	format_scoreboard board = new();
	int send_idle_pct = 8;
	int recv_idle_pct = 62;
	bit hold_off = 1'b0;
	int cycles = 0;

	printf_conversion_formatter dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("printf_conversion_formatter test failed");
			$finish;
		end
	end

	// Output side: check accepted transactions and choose the next stall.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_char(out_char, char_valid, last);
		out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
	end

	task automatic send_conversion(logic [7:0] fn, logic [5:0] fl, logic [6:0] w,
			logic [5:0] pr, logic [63:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= fn;
		flags <= fl;
		width <= w;
		precision <= pr;
		value <= v;
		do
			@(posedge clk);
		while (in_stall);
		board.note_conversion(fn, fl, w, pr, v);
		in_valid <= 1'b0;
		// The block stays busy after a transaction anyway.
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_func();
		case ($urandom_range(9))
			0: return pcf_pkg::CH_C;
			1: return pcf_pkg::CH_D;
			2: return pcf_pkg::CH_I;
			3: return pcf_pkg::CH_U;
			4: return pcf_pkg::CH_LX;
			5: return pcf_pkg::CH_UX;
			6: return pcf_pkg::CH_P;
			7: return pcf_pkg::CH_PCT;
			8: return 8'($urandom_range(255));
			default: return $urandom_range(1) ? pcf_pkg::CH_D : pcf_pkg::CH_LX;
		endcase
	endfunction

	function automatic logic [63:0] pick_value();
		case ($urandom_range(5))
			0: return '0;
			1: return {$urandom, $urandom};
			2: return {32'($urandom), 32'h8000_0000};
			3: return 64'($urandom_range(20));
			4: return {$urandom, 32'hffff_ffff};
			default: return {$urandom, $urandom} >> $urandom_range(63);
		endcase
	endfunction

	task automatic random_phase(int n);
		logic [6:0] w;
		for (int i = 0; i < n; i++) begin
			w = ($urandom_range(9) == 0) ? 7'($urandom_range(64)) : 7'($urandom_range(16));
			send_conversion(pick_func(), 6'($urandom_range(63)), w, 6'($urandom_range(60)),
				pick_value());
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed cases: extremes, each conversion and the corner cases.
		send_conversion(pcf_pkg::CH_C, 6'd0, 7'd0, 6'd0, 64'h41);
		send_conversion(pcf_pkg::CH_C, 6'b001000, 7'd5, 6'd0, 64'hff);
		send_conversion(pcf_pkg::CH_PCT, 6'b111111, 7'd3, 6'd60, '1);
		send_conversion(pcf_pkg::CH_D, 6'd0, 7'd0, 6'd0, 64'h8000_0000);
		send_conversion(pcf_pkg::CH_I, 6'b000010, 7'd12, 6'd0, 64'd123);
		send_conversion(pcf_pkg::CH_D, 6'b000100, 7'd0, 6'd0, 64'd7);
		send_conversion(pcf_pkg::CH_D, 6'b100000, 7'd0, 6'd0, 64'd0);
		send_conversion(pcf_pkg::CH_U, 6'b100000, 7'd4, 6'd0, 64'd0);
		send_conversion(pcf_pkg::CH_D, 6'b010000, 7'd10, 6'd0, 64'hffff_fff6);
		send_conversion(pcf_pkg::CH_D, 6'b110000, 7'd10, 6'd4, 64'd5);
		send_conversion(pcf_pkg::CH_D, 6'b011000, 7'd8, 6'd0, 64'd42);
		send_conversion(pcf_pkg::CH_U, 6'd0, 7'd0, 6'd0, 64'hffff_ffff);
		send_conversion(pcf_pkg::CH_LX, 6'b000001, 7'd0, 6'd0, 64'hdead_beef);
		send_conversion(pcf_pkg::CH_UX, 6'b010001, 7'd12, 6'd0, 64'hbeef);
		send_conversion(pcf_pkg::CH_LX, 6'b000001, 7'd0, 6'd0, 64'd0);
		send_conversion(pcf_pkg::CH_UX, 6'b100001, 7'd0, 6'd60, 64'd1);
		send_conversion(pcf_pkg::CH_P, 6'd0, 7'd0, 6'd0, '1);
		send_conversion(pcf_pkg::CH_P, 6'b111000, 7'd20, 6'd0, 64'd0);
		send_conversion(pcf_pkg::CH_P, 6'd0, 7'd64, 6'd0, 64'h1234);
		send_conversion(pcf_pkg::CH_D, 6'b000010, 7'd64, 6'd60, 64'd9);
		send_conversion(8'h71, 6'b111111, 7'd40, 6'd9, '1);
		send_conversion(8'h00, 6'd0, 7'd0, 6'd0, '0);
		send_conversion(8'hff, 6'd0, 7'd127, 6'd63, '0);
		drain();

		random_phase(120);
		send_idle_pct = 62;
		recv_idle_pct = 8;
		random_phase(120);

		// Long receiver hold-off while conversions keep coming.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			random_phase(4);
		join
		drain();
		random_phase(110);
		drain();
		repeat (100) @(posedge clk);

		if (board.errors == 0 && board.pending.size() == 0)
			$display("printf_conversion_formatter test passed");
		else
			$display("printf_conversion_formatter test failed");
		$finish;
	end
endmodule
